// ===== sv/iimt_pkg.sv =====
package iimt_pkg;

    // Default number of table slots
    localparam int TABLE_DEPTH_DEF = 16;

    // Field widths fixed by the interface
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 2 * VAL_W;

    typedef logic [STAT_W-1:0]       t_status;
    typedef logic signed [VAL_W-1:0] t_value;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Status codes
    localparam t_status ST_OK             = 2'd0;
    localparam t_status ST_FULL           = 2'd1;
    localparam t_status ST_BAD_INDEX      = 2'd2;
    localparam t_status ST_LOW_ABOVE_HIGH = 2'd3;

endpackage

// ===== sv/iimt_ram.sv =====
module iimt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/iimt_cmp.sv =====
module iimt_cmp (
    input  iimt_pkg::t_value i_a,
    input  iimt_pkg::t_value i_b,
    output logic             o_lt,
    output iimt_pkg::t_value o_min,
    output iimt_pkg::t_value o_max
);

    // Single signed comparator shared by the check, search and merge steps of the sequencer
    assign o_lt  = (i_a < i_b);
    assign o_min = o_lt ? i_a : i_b;
    assign o_max = o_lt ? i_b : i_a;

endmodule

// ===== sv/interval_insert_merge_table_core.sv =====
// Channel   Direction  Handshake             Payload
// command   in         start / busy          i_command, i_new_low, i_new_high, i_read_index
// result    out        o_valid strobe        o_status, o_entry_low, o_entry_high, o_slot,
//                                            o_absorbed_count, o_entry_count
//
// A read returns its result after a registered RAM read, or straight from the index check
// when the index is out of range. An insert spends a check step, then two binary searches
// over one registered-read table RAM, widens a merge in states S_M1 and S_M2, uses a read
// state and a write state for each entry moved to open or close a slot, and ends in a write.
// Reset is synchronous and empties the table at once; busy holds off new beats while
// a command is in flight, and the result strobe lasts one cycle with no stall.
module interval_insert_merge_table_core #(
    parameter int TABLE_DEPTH = iimt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic signed [iimt_pkg::VAL_W-1:0] i_new_low,
    input  logic signed [iimt_pkg::VAL_W-1:0] i_new_high,
    input  logic [iimt_pkg::IDX_W-1:0]     i_read_index,
    output logic                           o_valid,
    output logic [iimt_pkg::STAT_W-1:0]    o_status,
    output logic signed [iimt_pkg::VAL_W-1:0] o_entry_low,
    output logic signed [iimt_pkg::VAL_W-1:0] o_entry_high,
    output logic [iimt_pkg::IDX_W-1:0]     o_slot,
    output logic [iimt_pkg::CNT_W-1:0]     o_absorbed_count,
    output logic [iimt_pkg::CNT_W-1:0]     o_entry_count
);

    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMPW = (CW > iimt_pkg::IDX_W) ? CW : iimt_pkg::IDX_W;
    localparam int VW   = iimt_pkg::VAL_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_S1_PROBE = 4'd2;
    localparam logic [3:0] S_S1_CMP   = 4'd3;
    localparam logic [3:0] S_S2_PROBE = 4'd4;
    localparam logic [3:0] S_S2_CMP   = 4'd5;
    localparam logic [3:0] S_M1       = 4'd6;
    localparam logic [3:0] S_M2       = 4'd7;
    localparam logic [3:0] S_DN_RD    = 4'd8;
    localparam logic [3:0] S_DN_WR    = 4'd9;
    localparam logic [3:0] S_UP_RD    = 4'd10;
    localparam logic [3:0] S_UP_WR    = 4'd11;
    localparam logic [3:0] S_WRITE    = 4'd12;
    localparam logic [3:0] S_RD_WAIT  = 4'd13;

    logic [3:0]                r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic                      r_valid, n_valid;
    iimt_pkg::t_value          r_lo, n_lo;
    iimt_pkg::t_value          r_hi, n_hi;
    logic [CW-1:0]             r_bl, n_bl;
    logic [CW-1:0]             r_bh, n_bh;
    logic [CW-1:0]             r_first, n_first;
    logic [CW-1:0]             r_end, n_end;
    logic [CW-1:0]             r_abs, n_abs;
    logic [CW-1:0]             r_idx, n_idx;
    iimt_pkg::t_status         r_o_status, n_o_status;
    iimt_pkg::t_value          r_o_low, n_o_low;
    iimt_pkg::t_value          r_o_high, n_o_high;
    logic [iimt_pkg::IDX_W-1:0] r_o_slot, n_o_slot;
    logic [iimt_pkg::CNT_W-1:0] r_o_abs, n_o_abs;
    logic [iimt_pkg::CNT_W-1:0] r_o_cnt, n_o_cnt;

    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [iimt_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    iimt_pkg::t_value             rd_low, rd_high;

    iimt_pkg::t_value cmp_a, cmp_b, cmp_min, cmp_max;
    logic             cmp_lt;

    logic [CW:0]      w_sum;
    logic [CW-1:0]    w_mid;
    logic [CMPW-1:0]  w_idx_ext;
    logic [CMPW-1:0]  w_cnt_ext;
    logic [CW-1:0]    w_abs;
    logic [CW-1:0]    w_new_cnt;

    assign rd_low  = ram_rdata[iimt_pkg::ENTRY_W-1:VW];
    assign rd_high = ram_rdata[VW-1:0];

    assign w_sum     = {1'b0, r_bl} + {1'b0, r_bh};
    assign w_mid     = w_sum[CW:1];
    assign w_idx_ext = CMPW'(i_read_index);
    assign w_cnt_ext = CMPW'(r_count);
    assign w_abs     = r_bl - r_first;
    assign w_new_cnt = (r_abs != '0) ? CW'(r_count - r_abs + CW'(1)) : CW'(r_count + CW'(1));

    iimt_ram #(
        .WIDTH (iimt_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    iimt_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_lt  (cmp_lt),
        .o_min (cmp_min),
        .o_max (cmp_max)
    );

    // Route the comparator operands for the current step
    always_comb begin
        cmp_a = r_hi;
        cmp_b = r_lo;
        unique case (r_state)
            S_S1_CMP: begin
                cmp_a = rd_high;
                cmp_b = r_lo;
            end
            S_S2_CMP: begin
                cmp_a = r_hi;
                cmp_b = rd_low;
            end
            S_M1: begin
                cmp_a = rd_low;
                cmp_b = r_lo;
            end
            S_M2: begin
                cmp_a = rd_high;
                cmp_b = r_hi;
            end
            default: begin
                cmp_a = r_hi;
                cmp_b = r_lo;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_valid    = 1'b0;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_bl       = r_bl;
        n_bh       = r_bh;
        n_first    = r_first;
        n_end      = r_end;
        n_abs      = r_abs;
        n_idx      = r_idx;
        n_o_status = r_o_status;
        n_o_low    = r_o_low;
        n_o_high   = r_o_high;
        n_o_slot   = r_o_slot;
        n_o_abs    = r_o_abs;
        n_o_cnt    = r_o_cnt;
        ram_we     = 1'b0;
        ram_waddr  = r_first[AW-1:0];
        ram_wdata  = {r_lo, r_hi};
        ram_re     = 1'b0;
        ram_raddr  = w_mid[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_command == iimt_pkg::CMD_READ) begin
                        if (w_idx_ext >= w_cnt_ext) begin
                            n_valid    = 1'b1;
                            n_o_status = iimt_pkg::ST_BAD_INDEX;
                            n_o_low    = '0;
                            n_o_high   = '0;
                            n_o_slot   = '0;
                            n_o_abs    = '0;
                            n_o_cnt    = iimt_pkg::CNT_W'(r_count);
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = w_idx_ext[AW-1:0];
                            n_idx     = w_idx_ext[CW-1:0];
                            n_state   = S_RD_WAIT;
                        end
                    end else begin
                        n_lo    = i_new_low;
                        n_hi    = i_new_high;
                        n_state = S_CHECK;
                    end
                end
            end
            S_RD_WAIT: begin
                n_valid    = 1'b1;
                n_o_status = iimt_pkg::ST_OK;
                n_o_low    = rd_low;
                n_o_high   = rd_high;
                n_o_slot   = iimt_pkg::IDX_W'(r_idx);
                n_o_abs    = '0;
                n_o_cnt    = iimt_pkg::CNT_W'(r_count);
                n_state    = S_IDLE;
            end
            S_CHECK: begin
                if (cmp_lt) begin
                    n_valid    = 1'b1;
                    n_o_status = iimt_pkg::ST_LOW_ABOVE_HIGH;
                    n_o_low    = '0;
                    n_o_high   = '0;
                    n_o_slot   = '0;
                    n_o_abs    = '0;
                    n_o_cnt    = iimt_pkg::CNT_W'(r_count);
                    n_state    = S_IDLE;
                end else begin
                    n_bl    = '0;
                    n_bh    = r_count;
                    n_state = S_S1_PROBE;
                end
            end
            // First entry whose high reaches the new low
            S_S1_PROBE: begin
                if (r_bl == r_bh) begin
                    n_first = r_bl;
                    n_bh    = r_count;
                    n_state = S_S2_PROBE;
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_S1_CMP;
                end
            end
            S_S1_CMP: begin
                if (cmp_lt) begin
                    n_bl = CW'(w_mid + CW'(1));
                end else begin
                    n_bh = w_mid;
                end
                n_state = S_S1_PROBE;
            end
            // First entry that starts past the new high
            S_S2_PROBE: begin
                if (r_bl == r_bh) begin
                    n_end = r_bl;
                    n_abs = w_abs;
                    if (w_abs == '0) begin
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            n_valid    = 1'b1;
                            n_o_status = iimt_pkg::ST_FULL;
                            n_o_low    = '0;
                            n_o_high   = '0;
                            n_o_slot   = '0;
                            n_o_abs    = '0;
                            n_o_cnt    = iimt_pkg::CNT_W'(r_count);
                            n_state    = S_IDLE;
                        end else if (r_first == r_count) begin
                            n_state = S_WRITE;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_UP_RD;
                        end
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_first[AW-1:0];
                        n_state   = S_M1;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_S2_CMP;
                end
            end
            S_S2_CMP: begin
                if (!cmp_lt) begin
                    n_bl = CW'(w_mid + CW'(1));
                end else begin
                    n_bh = w_mid;
                end
                n_state = S_S2_PROBE;
            end
            // Widen to cover the first and last absorbed entries
            S_M1: begin
                n_lo      = cmp_min;
                ram_re    = 1'b1;
                ram_raddr = AW'(r_end - CW'(1));
                n_state   = S_M2;
            end
            S_M2: begin
                n_hi  = cmp_max;
                n_idx = r_end;
                if ((r_abs > CW'(1)) && (r_end < r_count)) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            // Close the gap: move entries down over the absorbed run
            S_DN_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx[AW-1:0];
                n_state   = S_DN_WR;
            end
            S_DN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_idx - r_abs + CW'(1));
                ram_wdata = ram_rdata;
                n_idx     = CW'(r_idx + CW'(1));
                if (CW'(r_idx + CW'(1)) < r_count) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            // Open a slot: move entries up from the top
            S_UP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_idx - CW'(1));
                n_state   = S_UP_WR;
            end
            S_UP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = ram_rdata;
                n_idx     = CW'(r_idx - CW'(1));
                if (CW'(r_idx - CW'(1)) > r_first) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we     = 1'b1;
                ram_waddr  = r_first[AW-1:0];
                ram_wdata  = {r_lo, r_hi};
                n_count    = w_new_cnt;
                n_valid    = 1'b1;
                n_o_status = iimt_pkg::ST_OK;
                n_o_low    = r_lo;
                n_o_high   = r_hi;
                n_o_slot   = iimt_pkg::IDX_W'(r_first);
                n_o_abs    = iimt_pkg::CNT_W'(r_abs);
                n_o_cnt    = iimt_pkg::CNT_W'(w_new_cnt);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_bl       <= n_bl;
        r_bh       <= n_bh;
        r_first    <= n_first;
        r_end      <= n_end;
        r_abs      <= n_abs;
        r_idx      <= n_idx;
        r_o_status <= n_o_status;
        r_o_low    <= n_o_low;
        r_o_high   <= n_o_high;
        r_o_slot   <= n_o_slot;
        r_o_abs    <= n_o_abs;
        r_o_cnt    <= n_o_cnt;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_o_status;
    assign o_entry_low      = r_o_low;
    assign o_entry_high     = r_o_high;
    assign o_slot           = r_o_slot;
    assign o_absorbed_count = r_o_abs;
    assign o_entry_count    = r_o_cnt;

endmodule

// ===== sv/iimt_checker.sv =====
module iimt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_valid,
    input logic [iimt_pkg::STAT_W-1:0]       o_status,
    input logic signed [iimt_pkg::VAL_W-1:0] o_entry_low,
    input logic signed [iimt_pkg::VAL_W-1:0] o_entry_high,
    input logic [iimt_pkg::IDX_W-1:0]        o_slot,
    input logic [iimt_pkg::CNT_W-1:0]        o_absorbed_count
);

    // Error results carry an empty payload
    a_err_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != iimt_pkg::ST_OK)) |->
        (o_entry_low == '0 && o_entry_high == '0 && o_slot == '0 && o_absorbed_count == '0))
        else $error("error result with nonzero payload");

    // Every reported interval is well formed
    a_ok_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == iimt_pkg::ST_OK)) |-> (o_entry_low <= o_entry_high))
        else $error("reported interval has low above high");

    // A result only follows an accepted beat or work in flight
    a_valid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a command");

    // Leaving busy always delivers the result
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

endmodule

bind interval_insert_merge_table_core iimt_checker u_iimt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_entry_low      (o_entry_low),
    .o_entry_high     (o_entry_high),
    .o_slot           (o_slot),
    .o_absorbed_count (o_absorbed_count)
);

// ===== tb/interval_insert_merge_table_core_tb.sv =====
`timescale 1ns / 100ps

module interval_insert_merge_table_core_tb;

    localparam int DEPTH  = iimt_pkg::TABLE_DEPTH_DEF;
    localparam int IDX_W  = iimt_pkg::IDX_W;
    localparam int CNT_W  = iimt_pkg::CNT_W;
    localparam int STAT_W = iimt_pkg::STAT_W;
    localparam iimt_pkg::t_value VAL_MIN = 32'sh8000_0000;
    localparam iimt_pkg::t_value VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        iimt_pkg::t_status status;
        iimt_pkg::t_value  lo;
        iimt_pkg::t_value  hi;
        logic [IDX_W-1:0]  slot;
        logic [CNT_W-1:0]  absorbed;
        logic [CNT_W-1:0]  count;
    } t_merge_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_command = iimt_pkg::CMD_INSERT;
    iimt_pkg::t_value     i_new_low = '0;
    iimt_pkg::t_value     i_new_high = '0;
    logic [IDX_W-1:0]     i_read_index = '0;
    logic                 o_valid;
    logic [STAT_W-1:0]    o_status;
    iimt_pkg::t_value     o_entry_low;
    iimt_pkg::t_value     o_entry_high;
    logic [IDX_W-1:0]     o_slot;
    logic [CNT_W-1:0]     o_absorbed_count;
    logic [CNT_W-1:0]     o_entry_count;

    // shadow copy of the interval table
    iimt_pkg::t_value tbl_low [DEPTH];
    iimt_pkg::t_value tbl_high [DEPTH];
    int               tbl_count = 0;
    t_merge_result    pending_results[$];
    int               mismatch_count = 0;
    bit               gaps_on = 1'b1;

    interval_insert_merge_table_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_new_low        (i_new_low),
        .i_new_high       (i_new_high),
        .i_read_index     (i_read_index),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_entry_low      (o_entry_low),
        .o_entry_high     (o_entry_high),
        .o_slot           (o_slot),
        .o_absorbed_count (o_absorbed_count),
        .o_entry_count    (o_entry_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_merge_result predict_table_op(logic cmd, iimt_pkg::t_value lo,
                                                       iimt_pkg::t_value hi,
                                                       logic [IDX_W-1:0] idx);
        t_merge_result r;
        int n;
        int run_first;
        int run_stop;
        int absorbed;
        int i;
        r = '0;
        n = tbl_count;
        r.count = CNT_W'(n);
        if (cmd == iimt_pkg::CMD_READ) begin
            if (int'(idx) >= n) begin
                r.status = iimt_pkg::ST_BAD_INDEX;
            end else begin
                r.status = iimt_pkg::ST_OK;
                r.lo = tbl_low[idx];
                r.hi = tbl_high[idx];
                r.slot = idx;
            end
            return r;
        end
        if (lo > hi) begin
            r.status = iimt_pkg::ST_LOW_ABOVE_HIGH;
            return r;
        end
        run_first = 0;
        while (run_first < n && tbl_high[run_first] < lo) run_first++;
        run_stop = run_first;
        while (run_stop < n && tbl_low[run_stop] <= hi) run_stop++;
        absorbed = run_stop - run_first;
        if (absorbed == 0 && n >= DEPTH) begin
            r.status = iimt_pkg::ST_FULL;
            return r;
        end
        if (absorbed > 0) begin
            if (tbl_low[run_first] < lo) lo = tbl_low[run_first];
            if (tbl_high[run_stop-1] > hi) hi = tbl_high[run_stop-1];
            // close the gap, keep one slot for the merged entry
            for (i = run_stop; i < n; i++) begin
                tbl_low[i-absorbed+1] = tbl_low[i];
                tbl_high[i-absorbed+1] = tbl_high[i];
            end
            n = n - absorbed + 1;
        end else begin
            for (i = n; i > run_first; i--) begin
                tbl_low[i] = tbl_low[i-1];
                tbl_high[i] = tbl_high[i-1];
            end
            n = n + 1;
        end
        tbl_low[run_first] = lo;
        tbl_high[run_first] = hi;
        tbl_count = n;
        r.status = iimt_pkg::ST_OK;
        r.lo = lo;
        r.hi = hi;
        r.slot = IDX_W'(run_first);
        r.absorbed = CNT_W'(absorbed);
        r.count = CNT_W'(n);
        return r;
    endfunction

    // Leaves start high; the caller lowers it in a pause or at the end.
    task automatic issue_command(logic cmd, iimt_pkg::t_value lo, iimt_pkg::t_value hi,
                                 logic [IDX_W-1:0] idx);
        start <= 1'b1;
        i_command <= cmd;
        i_new_low <= lo;
        i_new_high <= hi;
        i_read_index <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results = {pending_results, predict_table_op(cmd, lo, hi, idx)};
    endtask

    task automatic maybe_pause();
        if (gaps_on && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    endtask

    task automatic insert_interval(iimt_pkg::t_value lo, iimt_pkg::t_value hi);
        issue_command(iimt_pkg::CMD_INSERT, lo, hi, IDX_W'($urandom()));
        maybe_pause();
    endtask

    task automatic read_slot(logic [IDX_W-1:0] idx);
        issue_command(iimt_pkg::CMD_READ, iimt_pkg::t_value'($urandom()),
                      iimt_pkg::t_value'($urandom()), idx);
        maybe_pause();
    endtask

    task automatic test_empty_and_bad_bounds();
        read_slot(4'd15);
        insert_interval(VAL_MAX, VAL_MIN);
    endtask

    task automatic test_fill_to_capacity();
        // scrambled order forces entries to shift up to open slots; [1,2] and [3,4] stay apart
        iimt_pkg::t_value lows [DEPTH] = '{30, VAL_MAX, 3, -1000, 110, VAL_MIN, 1, 190,
                                           70, 10, 1000, 150, 50, 130, 90, 170};
        iimt_pkg::t_value highs [DEPTH] = '{40, VAL_MAX, 4, -900, 120, VAL_MIN, 2, 200,
                                            80, 20, 2000, 160, 60, 140, 100, 180};
        for (int k = 0; k < DEPTH; k++) insert_interval(lows[k], highs[k]);
    endtask

    task automatic test_full_and_merge_all();
        insert_interval(5, 8);
        read_slot(4'd15);
        // touches the endpoint of [30,40] only
        insert_interval(40, 45);
        insert_interval(VAL_MIN, VAL_MAX);
        read_slot(4'd0);
    endtask

    task automatic test_random_traffic(int items, bit with_gaps);
        iimt_pkg::t_value lo;
        iimt_pkg::t_value hi;
        longint wide;
        int pick;
        gaps_on = with_gaps;
        repeat (items) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                read_slot(IDX_W'($urandom()));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    hi = iimt_pkg::t_value'(int'($urandom_range(0, 600)) - 300);
                    lo = hi + iimt_pkg::t_value'($urandom_range(1, 50));
                end else if (pick < 13) begin
                    // narrow interval anywhere in the full range
                    lo = iimt_pkg::t_value'($urandom());
                    wide = longint'(lo) + longint'($urandom_range(0, 1000));
                    hi = (wide > longint'(VAL_MAX)) ? VAL_MAX : iimt_pkg::t_value'(wide);
                end else if (pick < 15) begin
                    lo = iimt_pkg::t_value'(-400 - int'($urandom_range(0, 100)));
                    hi = iimt_pkg::t_value'(400 + int'($urandom_range(0, 100)));
                end else begin
                    lo = iimt_pkg::t_value'(int'($urandom_range(0, 600)) - 300);
                    hi = lo + iimt_pkg::t_value'($urandom_range(0, 8));
                end
                insert_interval(lo, hi);
            end
        end
    endtask

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_merge_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected, status %0d", $time, o_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_status);
                check_field("entry_low", longint'($signed(want.lo)),
                            longint'($signed(o_entry_low)));
                check_field("entry_high", longint'($signed(want.hi)),
                            longint'($signed(o_entry_high)));
                check_field("slot", want.slot, o_slot);
                check_field("absorbed_count", want.absorbed, o_absorbed_count);
                check_field("entry_count", want.count, o_entry_count);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_bad_bounds();
        test_fill_to_capacity();
        test_full_and_merge_all();
        test_random_traffic(450, 1'b1);
        test_random_traffic(350, 1'b0);
        test_random_traffic(450, 1'b1);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
